### hdl/jscs_pkg.sv
// ----------------------------------------------------------------------------
// jscs_pkg
// Shared types and constants for the JTAG scan chunk shifter.
// ----------------------------------------------------------------------------
package jscs_pkg;

	localparam logic [1:0] CMD_TMS_SEQ    = 2'd0;
	localparam logic [1:0] CMD_SHIFT      = 2'd1;
	localparam logic [1:0] CMD_SHIFT_CAP  = 2'd2;
	localparam logic [1:0] CMD_TEST_RESET = 2'd3;

	localparam logic [3:0] MAX_BITS      = 4'd8;
	localparam logic [3:0] RESET_PULSES  = 4'd6;
	localparam logic [15:0] HALF_PERIOD_RESET = 16'd1;

	localparam int JSCS_QUEUE_DEPTH = 2;

	// One classified chunk as it waits for the pulse generator.
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data;
		logic [3:0] count;
		logic       last_chunk;
		logic [7:0] tdo;
	} desc_t;

endpackage

### hdl/jscs_front.sv
// ----------------------------------------------------------------------------
// jscs_front
// Accepts chunk requests, saturates the bit count, sets six pulses for a test
// reset, drops empty chunks and hands the rest to the command queue.
// ----------------------------------------------------------------------------
module jscs_front
	import jscs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] data_byte,
	input  logic [3:0] bit_count,
	input  logic       last_chunk,
	input  logic [7:0] tdo_levels,
	output logic       push,
	output desc_t      push_desc,
	input  logic       queue_full
);

	logic       valid_s1;
	desc_t      desc_s1;
	desc_t      desc_in;
	logic       keep;
	logic       load;

	always_comb begin
		desc_in.cmd        = command;
		desc_in.data       = data_byte;
		desc_in.last_chunk = last_chunk;
		desc_in.tdo        = tdo_levels;
		if (command == CMD_TEST_RESET) begin
			desc_in.count = RESET_PULSES;
		end else if (bit_count > MAX_BITS) begin
			desc_in.count = MAX_BITS;
		end else begin
			desc_in.count = bit_count;
		end
	end

	// A chunk with no bits, other than a test reset, makes no pulses, so it never enters the queue.
	assign keep     = (command == CMD_TEST_RESET) || (bit_count != 4'd0);
	assign in_stall = valid_s1 && queue_full;
	assign load     = !in_stall;
	assign push     = valid_s1 && !queue_full;
	assign push_desc = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			desc_s1 <= desc_in;
		end
	end

endmodule

### hdl/jscs_queue.sv
// ----------------------------------------------------------------------------
// jscs_queue
// Small register queue of classified chunks between front and back.
// ----------------------------------------------------------------------------
module jscs_queue
	import jscs_pkg::*;
#(
	parameter int DEPTH = JSCS_QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output desc_t pop_desc,
	output logic  empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	desc_t           entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == FullCnt);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_desc = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

### hdl/jscs_back.sv
// ----------------------------------------------------------------------------
// jscs_back
// Pulse generator: takes one chunk at a time from the queue and emits one
// result per TCK pulse, paced by the half period, into an output register.
// ----------------------------------------------------------------------------
module jscs_back
	import jscs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] half_period,
	input  logic        queue_empty,
	input  desc_t       queue_desc,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tdi_level,
	output logic        tms_level,
	output logic        trst_level,
	output logic [7:0]  captured_byte,
	output logic        last_pulse
);

	logic        busy_q;
	desc_t       desc_q;
	logic [2:0]  idx_q;
	logic [16:0] timer_q;
	logic        out_valid_q;
	logic        tdi_q;
	logic        tms_q;
	logic        trst_q;
	logic [7:0]  cap_q;
	logic        last_q;

	logic        slot_free;
	logic        emit;
	logic        fin;
	logic        bit_now;
	logic [7:0]  cap_mask;
	logic        tdi_n;
	logic        tms_n;
	logic        trst_n;
	logic [7:0]  cap_n;
	logic [15:0] hp_eff;
	logic [16:0] reload;

	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = busy_q && (timer_q == '0) && slot_free;
	assign pop       = !busy_q && !queue_empty;
	assign fin       = ({1'b0, idx_q} + 4'd1) == desc_q.count;
	assign bit_now   = desc_q.data[idx_q];

	// A zero half period paces like a half period of one.
	assign hp_eff = (half_period == '0) ? 16'd1 : half_period;
	assign reload = {hp_eff, 1'b0} - 17'd1;

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			cap_mask[j] = (3'(j) <= idx_q);
		end
	end

	always_comb begin
		tdi_n  = bit_now;
		tms_n  = fin && desc_q.last_chunk;
		trst_n = 1'b1;
		cap_n  = 8'h00;
		case (desc_q.cmd)
			CMD_TMS_SEQ: begin
				tdi_n = 1'b1;
				tms_n = bit_now;
			end
			CMD_SHIFT: begin
			end
			CMD_SHIFT_CAP: begin
				cap_n = desc_q.tdo & cap_mask;
			end
			CMD_TEST_RESET: begin
				tdi_n  = 1'b1;
				tms_n  = 1'b1;
				trst_n = fin;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			timer_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				busy_q <= !fin;
				idx_q  <= idx_q + 1'b1;
			end
			// The timer keeps running across chunks so every pulse gets its
			// full two half periods.
			if (emit) begin
				timer_q <= reload;
			end else if (timer_q != '0) begin
				timer_q <= timer_q - 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= queue_desc;
		end
		if (emit) begin
			tdi_q  <= tdi_n;
			tms_q  <= tms_n;
			trst_q <= trst_n;
			cap_q  <= cap_n;
			last_q <= fin;
		end
	end

	assign out_valid     = out_valid_q;
	assign tdi_level     = tdi_q;
	assign tms_level     = tms_q;
	assign trst_level    = trst_q;
	assign captured_byte = cap_q;
	assign last_pulse    = last_q;

endmodule

### hdl/jtag_scan_chunk_shifter_unit.sv
// ----------------------------------------------------------------------------
// jtag_scan_chunk_shifter_unit
// JTAG master bit shifter: one scan chunk per request, one result per pulse.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes a chunk request: command, up to
// eight data bits sent bit 0 first, bit count, last-chunk flag and the TDO
// levels the target shows. Output channel (out_valid / out_stall) gives one
// result per TCK pulse: TDI, TMS and TRST levels, captured TDO bits and a
// flag on the final pulse of the request. Chunks with a zero bit count give
// no results; a test reset always gives six.
// A front stage classifies requests into a small queue, so new requests are
// taken while the pulse generator works. Each pulse takes two TCK half
// periods unless the output stalls. A request passes the front stage
// register, the queue and the generator's chunk register before its first
// result is registered. The pulse timer sets the rate. A stalled output
// holds its result and the generator waits for it. Reset empties the queue
// and the output and sets the half period to 1. The half period is written
// through wr_en / wr_data; the user must do so only while idle (not enforced).
// ----------------------------------------------------------------------------
module jtag_scan_chunk_shifter_unit
	import jscs_pkg::*;
#(
	parameter int QUEUE_DEPTH = JSCS_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [15:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic [3:0]  bit_count,
	input  logic        last_chunk,
	input  logic [7:0]  tdo_levels,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tdi_level,
	output logic        tms_level,
	output logic        trst_level,
	output logic [7:0]  captured_byte,
	output logic        last_pulse
);

	logic [15:0] half_period_q;
	logic        push;
	desc_t       push_desc;
	logic        queue_full;
	logic        pop;
	desc_t       pop_desc;
	logic        queue_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (wr_en) begin
			half_period_q <= wr_data;
		end
	end

	jscs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.data_byte  (data_byte),
		.bit_count  (bit_count),
		.last_chunk (last_chunk),
		.tdo_levels (tdo_levels),
		.push       (push),
		.push_desc  (push_desc),
		.queue_full (queue_full)
	);

	jscs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (queue_full),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.empty     (queue_empty)
	);

	jscs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.half_period   (half_period_q),
		.queue_empty   (queue_empty),
		.queue_desc    (pop_desc),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tdi_level     (tdi_level),
		.tms_level     (tms_level),
		.trst_level    (trst_level),
		.captured_byte (captured_byte),
		.last_pulse    (last_pulse)
	);

endmodule

### hdl/jscs_checker.sv
// ----------------------------------------------------------------------------
// jscs_checker
// Port-level checks for the JTAG scan chunk shifter, bound to the top level.
// ----------------------------------------------------------------------------
module jscs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       tdi_level,
	input logic       tms_level,
	input logic       trst_level,
	input logic [7:0] captured_byte,
	input logic       last_pulse
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result withdrawn");

	// Pulses that drive TRST low hold TDI and TMS high and never end the request.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !trst_level |-> tdi_level && tms_level && !last_pulse)
		else $error("bad test reset pulse");

	// Captured bits only come from a capture, which never drives TRST low.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (captured_byte != 8'h00) |-> trst_level)
		else $error("capture data during test reset");

	// A stalled result keeps all of its fields until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			$stable({tdi_level, tms_level, trst_level, captured_byte, last_pulse}))
		else $error("stalled result changed");

endmodule

bind jtag_scan_chunk_shifter_unit jscs_checker u_jscs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.tdi_level     (tdi_level),
	.tms_level     (tms_level),
	.trst_level    (trst_level),
	.captured_byte (captured_byte),
	.last_pulse    (last_pulse)
);
